// ===== rtl/core/pmob_pkg.sv =====
package pmob_pkg;

  localparam int PIX_W      = 8;
  localparam int COVER_W    = 4;
  localparam int RANK_W     = 2;
  localparam int STRENGTH_W = 9;
  localparam int MODE_W     = 2;
  localparam int COLOUR_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MASK_COUNT_DEFAULT = 4;
  localparam int MASK_COUNT_MAX     = 4;
  localparam int QUEUE_DEPTH        = 2;

  // full opacity in Q8
  localparam logic [STRENGTH_W-1:0] STRENGTH_FULL = 9'd256;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST  = 9'd128;
  localparam logic [COLOUR_W-1:0]   COLOUR_RST    = 24'hFFFFFF;

  // reciprocal of three in Q11; exact floor for sums up to 765
  localparam logic [9:0] RECIP3   = 10'd683;
  localparam int         RECIP3_SH = 11;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR0   = 3'd3;

  localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGBA = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0]      pix0;
    logic [PIX_W-1:0]      pix1;
    logic [PIX_W-1:0]      pix2;
    logic [PIX_W-1:0]      alpha;
    logic [PIX_W-1:0]      col0;
    logic [PIX_W-1:0]      col1;
    logic [PIX_W-1:0]      col2;
    logic [STRENGTH_W-1:0] strength;
    logic                  painted;
    logic [RANK_W-1:0]     rank;
    logic                  gray;
  } pmob_work_t;

  typedef struct packed {
    logic       valid;
    pmob_work_t data;
  } pmob_push_t;

  typedef struct packed {
    logic       valid;
    pmob_work_t data;
  } pmob_pop_t;

endpackage

// ===== rtl/core/pmob_if.sv =====
interface pmob_in_if;
  import pmob_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   chan_zero;
  logic [PIX_W-1:0]   chan_one;
  logic [PIX_W-1:0]   chan_two;
  logic [PIX_W-1:0]   chan_alpha;
  logic [COVER_W-1:0] cover_bits;

  modport source (output valid, chan_zero, chan_one, chan_two, chan_alpha, cover_bits,
                  input ready);
  modport sink (input valid, chan_zero, chan_one, chan_two, chan_alpha, cover_bits,
                output ready);
endinterface

interface pmob_out_if;
  import pmob_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  out_zero;
  logic [PIX_W-1:0]  out_one;
  logic [PIX_W-1:0]  out_two;
  logic [PIX_W-1:0]  out_alpha;
  logic              was_painted;
  logic [RANK_W-1:0] winner_rank;

  modport source (output valid, out_zero, out_one, out_two, out_alpha, was_painted,
                  winner_rank, input ready);
  modport sink (input valid, out_zero, out_one, out_two, out_alpha, was_painted,
                winner_rank, output ready);
endinterface

// ===== rtl/core/pmob_front.sv =====
module pmob_front #(
  parameter int MASK_COUNT = pmob_pkg::MASK_COUNT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmob_pkg::CFG_DATA_W-1:0]  cfg_data,
  pmob_in_if.sink                          in_chan,
  input  logic                             q_full,
  output pmob_pkg::pmob_push_t             push
);
  import pmob_pkg::*;

  logic [STRENGTH_W-1:0] strength_r;
  logic [MODE_W-1:0]     mode_r;
  logic                  red_first_r;
  logic [COLOUR_W-1:0]   colour_r [MASK_COUNT];

  logic                  painted;
  logic [RANK_W-1:0]     rank;
  logic [COLOUR_W-1:0]   colour;
  logic [PIX_W-1:0]      red, green, blue;
  logic [9:0]            sum3;
  logic [19:0]           avg_prod;
  logic                  gray;
  logic [STRENGTH_W-1:0] strength_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r  <= STRENGTH_RST;
      mode_r      <= MODE_RGB;
      red_first_r <= 1'b0;
      for (int i = 0; i < MASK_COUNT; i++) begin
        colour_r[i] <= COLOUR_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRENGTH:  strength_r  <= cfg_data[STRENGTH_W-1:0];
        REG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        REG_RED_FIRST: red_first_r <= cfg_data[0];
        default: begin
          for (int i = 0; i < MASK_COUNT; i++) begin
            if (cfg_index == REG_COLOUR0 + CFG_IDX_W'(i)) begin
              colour_r[i] <= cfg_data[COLOUR_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // lowest set cover bit wins; walk down so the lowest index is applied last
  always_comb begin
    painted = 1'b0;
    rank    = '0;
    colour  = colour_r[0];
    for (int i = MASK_COUNT - 1; i >= 0; i--) begin
      if (in_chan.cover_bits[i]) begin
        painted = 1'b1;
        rank    = RANK_W'(i);
        colour  = colour_r[i];
      end
    end
  end

  assign red   = colour[23:16];
  assign green = colour[15:8];
  assign blue  = colour[7:0];
  assign sum3  = 10'(red) + 10'(green) + 10'(blue);
  assign avg_prod = 20'(sum3) * 20'(RECIP3);
  assign gray  = (mode_r == MODE_GRAY);
  assign strength_sat = (strength_r > STRENGTH_FULL) ? STRENGTH_FULL : strength_r;

  assign in_chan.ready = !q_full;

  always_comb begin
    push.valid         = in_chan.valid && !q_full;
    push.data.pix0     = in_chan.chan_zero;
    push.data.pix1     = in_chan.chan_one;
    push.data.pix2     = in_chan.chan_two;
    push.data.alpha    = in_chan.chan_alpha;
    push.data.col0     = gray ? avg_prod[RECIP3_SH+PIX_W-1:RECIP3_SH]
                              : (red_first_r ? red : blue);
    push.data.col1     = green;
    push.data.col2     = red_first_r ? blue : red;
    push.data.strength = strength_sat;
    push.data.painted  = painted;
    push.data.rank     = rank;
    push.data.gray     = gray;
  end

endmodule

// ===== rtl/core/pmob_queue.sv =====
module pmob_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmob_pkg::pmob_push_t push,
  output logic                 full,
  input  logic                 pop_ready,
  output pmob_pkg::pmob_pop_t  pop
);
  import pmob_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  pmob_work_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign do_push = push.valid && !full;
  assign do_pop  = pop_ready && (count_r != '0);

  assign pop.valid = (count_r != '0);
  assign pop.data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.data;
    end
  end

endmodule

// ===== rtl/core/pmob_back.sv =====
module pmob_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pmob_pkg::pmob_pop_t pop,
  output logic                pop_ready,
  pmob_out_if.source          out_chan
);
  import pmob_pkg::*;

  function automatic logic [PIX_W-1:0] mix8(input logic [PIX_W-1:0] pix,
                                            input logic [PIX_W-1:0] col,
                                            input logic [STRENGTH_W-1:0] a);
    logic [STRENGTH_W-1:0] inv;
    logic [16:0]           acc;
    inv = STRENGTH_FULL - a;
    acc = 17'(pix) * 17'(inv) + 17'(col) * 17'(a);
    return acc[15:8];
  endfunction

  logic              out_valid_r;
  logic [PIX_W-1:0]  zero_r, one_r, two_r, alpha_r;
  logic              painted_r;
  logic [RANK_W-1:0] rank_r;
  logic [PIX_W-1:0]  zero_nxt, one_nxt, two_nxt;
  logic              load;

  assign load      = pop.valid && (!out_valid_r || out_chan.ready);
  assign pop_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    zero_nxt = pop.data.pix0;
    one_nxt  = pop.data.pix1;
    two_nxt  = pop.data.pix2;
    if (pop.data.painted) begin
      zero_nxt = mix8(pop.data.pix0, pop.data.col0, pop.data.strength);
      one_nxt  = mix8(pop.data.pix1, pop.data.col1, pop.data.strength);
      two_nxt  = mix8(pop.data.pix2, pop.data.col2, pop.data.strength);
    end
    // grayscale drops the color channels
    if (pop.data.gray) begin
      one_nxt = '0;
      two_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      zero_r    <= zero_nxt;
      one_r     <= one_nxt;
      two_r     <= two_nxt;
      alpha_r   <= pop.data.alpha;
      painted_r <= pop.data.painted;
      rank_r    <= pop.data.rank;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_zero    = zero_r;
  assign out_chan.out_one     = one_r;
  assign out_chan.out_two     = two_r;
  assign out_chan.out_alpha   = alpha_r;
  assign out_chan.was_painted = painted_r;
  assign out_chan.winner_rank = rank_r;

endmodule

// ===== rtl/core/priority_mask_overlay_blend.sv =====
// Priority mask overlay blend.
// in_chan carries one pixel (three channel bytes, alpha, mask cover bits) per
// item; out_chan returns one blended pixel per item, in order. Bit 0 of
// cover_bits is the top-priority mask; the lowest covering mask paints the
// pixel with its color at the opacity set by the strength register (Q8).
// Configuration goes through cfg_we / cfg_index / cfg_data, one register per
// write; the user must write only while no item is in flight, which the block
// itself does not enforce. Throughput: one item per cycle unless the queue
// is full; the front end classifies the pixel and picks the mask color, a
// two-entry queue decouples it from the back end, which runs the three blend
// multiplies and holds the result in the output register.
// If the receiver stalls, the output register holds its item, the queue
// absorbs up to two more, and then in_chan.ready drops until it drains.
// Reset (rst_n low, synchronous) empties the queue and output register and
// restores strength 128, three-channel mode, blue first and white masks.
module priority_mask_overlay_blend #(
  parameter int MASK_COUNT = pmob_pkg::MASK_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pmob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmob_pkg::CFG_DATA_W-1:0] cfg_data,
  pmob_in_if.sink                         in_chan,
  pmob_out_if.source                      out_chan
);
  import pmob_pkg::*;

  pmob_push_t push;
  pmob_pop_t  pop;
  logic       q_full;
  logic       pop_ready;

  pmob_front #(
    .MASK_COUNT (MASK_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push)
  );

  pmob_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .pop_ready (pop_ready),
    .pop       (pop)
  );

  pmob_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

// ===== rtl/core/pmob_checker.sv =====
module pmob_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_painted,
  input logic [pmob_pkg::RANK_W-1:0]  out_rank,
  input logic [pmob_pkg::PIX_W-1:0]   out_zero
);
  import pmob_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_zero))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // an unpainted pixel reports rank zero
  a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_painted |-> out_rank == '0)
    else $error("rank set on unpainted pixel");

  // back pressure reaches the input only behind a held result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind priority_mask_overlay_blend pmob_checker u_pmob_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_painted (out_chan.was_painted),
  .out_rank    (out_chan.winner_rank),
  .out_zero    (out_chan.out_zero)
);

// ===== bench/priority_mask_overlay_blend_test.sv =====
module priority_mask_overlay_blend_test;
  import pmob_pkg::*;

  localparam int MASKS = MASK_COUNT_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_RGBA_ALT = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    logic [PIX_W-1:0]   chan0;
    logic [PIX_W-1:0]   chan1;
    logic [PIX_W-1:0]   chan2;
    logic [PIX_W-1:0]   alpha;
    logic [COVER_W-1:0] cover_bits;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]  chan0;
    logic [PIX_W-1:0]  chan1;
    logic [PIX_W-1:0]  chan2;
    logic [PIX_W-1:0]  alpha;
    logic              painted;
    logic [RANK_W-1:0] rank;
  } blended_t;

  typedef struct packed {
    logic [STRENGTH_W-1:0] strength;
    logic [MODE_W-1:0]     mode;
    logic                  red_first;
    logic [COLOUR_W-1:0]   colour;
    pixel_t                px;
    logic                  known;
    blended_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmob_in_if  in_bus ();
  pmob_out_if out_bus ();

  priority_mask_overlay_blend uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // mirror of the block's registers
  logic [STRENGTH_W-1:0] cfg_strength;
  logic [MODE_W-1:0]     cfg_mode;
  logic                  cfg_red_first;
  logic [COLOUR_W-1:0]   cfg_colour [MASKS];

  blended_t  blend_q[$];
  stim_row_t stim_rows[$];
  logic      offered_known;
  blended_t  offered_want;
  int        n_sent;
  int        n_checked;
  int        n_errors;
  int        burst_left;
  bit        hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [PIX_W-1:0] mix_q8(input logic [PIX_W-1:0] pix,
                                               input logic [PIX_W-1:0] col,
                                               input logic [STRENGTH_W-1:0] a);
    logic [16:0] acc;
    acc = {9'd0, pix} * (17'd256 - {8'd0, a}) + {9'd0, col} * {8'd0, a};
    return acc[15:8];
  endfunction

  function automatic blended_t blend_pixel(input pixel_t px);
    blended_t              res;
    logic [STRENGTH_W-1:0] a;
    logic [COLOUR_W-1:0]   col;
    logic [PIX_W-1:0]      c0;
    logic [PIX_W-1:0]      c2;
    logic [9:0]            sum;
    res.chan0   = px.chan0;
    res.chan1   = px.chan1;
    res.chan2   = px.chan2;
    res.alpha   = px.alpha;
    res.painted = 1'b0;
    res.rank    = '0;
    a = (cfg_strength > STRENGTH_FULL) ? STRENGTH_FULL : cfg_strength;
    // scan from the bottom so the top-priority cover wins
    for (int i = MASKS - 1; i >= 0; i--) begin
      if (px.cover_bits[i]) begin
        res.painted = 1'b1;
        res.rank    = RANK_W'(i);
      end
    end
    if (res.painted) begin
      col = cfg_colour[res.rank];
      if (cfg_mode == MODE_GRAY) begin
        sum = {2'b0, col[23:16]} + {2'b0, col[15:8]} + {2'b0, col[7:0]};
        res.chan0 = mix_q8(px.chan0, 8'(sum / 10'd3), a);
      end else begin
        c0 = cfg_red_first ? col[23:16] : col[7:0];
        c2 = cfg_red_first ? col[7:0] : col[23:16];
        res.chan0 = mix_q8(px.chan0, c0, a);
        res.chan1 = mix_q8(px.chan1, col[15:8], a);
        res.chan2 = mix_q8(px.chan2, c2, a);
      end
    end
    if (cfg_mode == MODE_GRAY) begin
      res.chan1 = '0;
      res.chan2 = '0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input blended_t got, input blended_t want);
    n_errors++;
    $display("item %0d %s: got %h %h %h %h p%b r%0d, want %h %h %h %h p%b r%0d",
             n_checked, what, got.chan0, got.chan1, got.chan2, got.alpha, got.painted,
             got.rank, want.chan0, want.chan1, want.chan2, want.alpha, want.painted,
             want.rank);
  endtask

  always @(posedge clk) begin : check_results
    blended_t got;
    blended_t want;
    pixel_t   px;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        px = {in_bus.chan_zero, in_bus.chan_one, in_bus.chan_two, in_bus.chan_alpha,
              in_bus.cover_bits};
        blend_q.insert(blend_q.size(), offered_known ? offered_want : blend_pixel(px));
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.out_zero, out_bus.out_one, out_bus.out_two, out_bus.out_alpha,
               out_bus.was_painted, out_bus.winner_rank};
        if (blend_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", got, '0);
        end else begin
          want = blend_q.pop_front();
          if (got.chan0 !== want.chan0 || got.chan1 !== want.chan1 ||
              got.chan2 !== want.chan2 || got.alpha !== want.alpha ||
              got.painted !== want.painted || got.rank !== want.rank)
            report_mismatch("differs", got, want);
          n_checked++;
        end
      end
    end
  end

  // receiver: ready pattern switches among four randomly chosen styles
  initial begin : receiver
    int style;
    int left;
    out_bus.ready <= 1'b0;
    style = 0;
    left  = 0;
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(16, 80);
      end
      left--;
      case (style)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        2: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default: out_bus.ready <= left[0];
      endcase
      @(posedge clk);
    end
  end

  task automatic offer_pixel(input pixel_t px, input logic known, input blended_t want);
    in_bus.valid      <= 1'b1;
    in_bus.chan_zero  <= px.chan0;
    in_bus.chan_one   <= px.chan1;
    in_bus.chan_two   <= px.chan2;
    in_bus.chan_alpha <= px.alpha;
    in_bus.cover_bits <= px.cover_bits;
    offered_known     <= known;
    offered_want      <= want;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (n_checked != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_STRENGTH:  cfg_strength  = data[STRENGTH_W-1:0];
      REG_MODE:      cfg_mode      = data[MODE_W-1:0];
      REG_RED_FIRST: cfg_red_first = data[0];
      default:       cfg_colour[2'(idx - REG_COLOUR0)] = data[COLOUR_W-1:0];
    endcase
  endtask

  task automatic commit_config(input logic [STRENGTH_W-1:0] s, input logic [MODE_W-1:0] m,
                               input logic r, input logic [COLOUR_W-1:0] c0,
                               input logic [COLOUR_W-1:0] c1, input logic [COLOUR_W-1:0] c2,
                               input logic [COLOUR_W-1:0] c3);
    drain_results();
    write_reg(REG_STRENGTH, CFG_DATA_W'(s));
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_RED_FIRST, CFG_DATA_W'(r));
    write_reg(REG_COLOUR0, c0);
    write_reg(REG_COLOUR0 + 3'd1, c1);
    write_reg(REG_COLOUR0 + 3'd2, c2);
    write_reg(REG_COLOUR0 + 3'd3, c3);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic [STRENGTH_W-1:0] s, input logic [MODE_W-1:0] m,
                         input logic r, input logic [COLOUR_W-1:0] c, input pixel_t px,
                         input logic known, input blended_t want);
    stim_row_t row;
    row.strength  = s;
    row.mode      = m;
    row.red_first = r;
    row.colour    = c;
    row.px        = px;
    row.known     = known;
    row.want      = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.chan0      = 8'($urandom_range(0, 255));
    px.chan1      = 8'($urandom_range(0, 255));
    px.chan2      = 8'($urandom_range(0, 255));
    px.alpha      = 8'($urandom_range(0, 255));
    px.cover_bits = 4'($urandom_range(0, 15));
    return px;
  endfunction

  initial begin : stimulus
    stim_row_t             row;
    logic [STRENGTH_W-1:0] s;
    logic [MODE_W-1:0]     m;
    logic [COLOUR_W-1:0]   c [MASKS];

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.chan_zero  <= '0;
    in_bus.chan_one   <= '0;
    in_bus.chan_two   <= '0;
    in_bus.chan_alpha <= '0;
    in_bus.cover_bits <= '0;
    offered_known     <= 1'b0;
    offered_want      <= '0;
    n_sent     = 0;
    n_checked  = 0;
    n_errors   = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    cfg_strength  = STRENGTH_RST;
    cfg_mode      = MODE_RGB;
    cfg_red_first = 1'b0;
    for (int k = 0; k < MASKS; k++) cfg_colour[k] = COLOUR_RST;

    // reset settings: half strength, three channels, blue first, white masks
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'h00, 4'h0}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h0}, 1'b1,
            {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 2'd0});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'hA5, 4'h1}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'hA5, 1'b1, 2'd0});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h80, 8'h80, 8'h80, 8'h3C, 4'h2}, 1'b1,
            {8'hBF, 8'hBF, 8'hBF, 8'h3C, 1'b1, 2'd1});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'hFF, 8'h00, 8'hFF, 8'h00, 4'h4}, 1'b1,
            {8'hFF, 8'h7F, 8'hFF, 8'h00, 1'b1, 2'd2});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'hFF, 8'h00, 8'hFF, 4'h8}, 1'b1,
            {8'h7F, 8'hFF, 8'h7F, 8'hFF, 1'b1, 2'd3});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'h11, 4'hF}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'h11, 1'b1, 2'd0});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'h22, 4'hC}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'h22, 1'b1, 2'd2});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'h33, 4'hA}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'h33, 1'b1, 2'd1});
    add_row(9'd128, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h55, 8'hAA, 8'h55, 8'hAA, 4'h6}, 1'b0, '0);
    // strength extremes, including values past full that must saturate
    add_row(9'd256, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h12, 8'h34, 8'h56, 8'h78, 4'h1}, 1'b1,
            {8'hFF, 8'hFF, 8'hFF, 8'h78, 1'b1, 2'd0});
    add_row(9'd0, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h12, 8'h34, 8'h56, 8'h78, 4'h1}, 1'b1,
            {8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 2'd0});
    add_row(9'd511, MODE_RGB, 1'b0, 24'hFFFFFF, {8'h12, 8'h34, 8'h56, 8'h78, 4'h3}, 1'b1,
            {8'hFF, 8'hFF, 8'hFF, 8'h78, 1'b1, 2'd0});
    add_row(9'd300, MODE_RGB, 1'b0, 24'h00FF00, {8'h9A, 8'h12, 8'h3B, 8'h78, 4'h2}, 1'b0, '0);
    // channel order
    add_row(9'd256, MODE_RGB, 1'b0, 24'hFF0000, {8'h10, 8'h20, 8'h30, 8'h40, 4'h1}, 1'b1,
            {8'h00, 8'h00, 8'hFF, 8'h40, 1'b1, 2'd0});
    add_row(9'd256, MODE_RGB, 1'b1, 24'hFF0000, {8'h10, 8'h20, 8'h30, 8'h40, 4'h1}, 1'b1,
            {8'hFF, 8'h00, 8'h00, 8'h40, 1'b1, 2'd0});
    // grayscale clears channels one and two, painted or not
    add_row(9'd256, MODE_GRAY, 1'b0, 24'hFFFFFF, {8'h10, 8'h20, 8'h30, 8'h40, 4'h2}, 1'b1,
            {8'hFF, 8'h00, 8'h00, 8'h40, 1'b1, 2'd1});
    add_row(9'd256, MODE_GRAY, 1'b0, 24'hFFFFFF, {8'h10, 8'h20, 8'h30, 8'h40, 4'h0}, 1'b1,
            {8'h10, 8'h00, 8'h00, 8'h40, 1'b0, 2'd0});
    add_row(9'd128, MODE_GRAY, 1'b1, 24'h030609, {8'hC8, 8'h20, 8'h30, 8'h40, 4'h8}, 1'b0, '0);
    // four-channel modes, including the unnamed code
    add_row(9'd128, MODE_RGBA, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'hEE, 4'h1}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'hEE, 1'b1, 2'd0});
    add_row(9'd128, MODE_RGBA_ALT, 1'b0, 24'hFFFFFF, {8'h00, 8'h00, 8'h00, 8'hEE, 4'h1}, 1'b1,
            {8'h7F, 8'h7F, 8'h7F, 8'hEE, 1'b1, 2'd0});
    add_row(9'd77, MODE_RGBA_ALT, 1'b1, 24'h123456, {8'h21, 8'h43, 8'h65, 8'h87, 4'h3}, 1'b0,
            '0);
    add_row(9'd256, MODE_RGB, 1'b0, 24'h000000, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h1}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 2'd0});
    add_row(9'd129, MODE_RGB, 1'b1, 24'hABCDEF, {8'h5A, 8'hA5, 8'hC3, 8'h3C, 4'h5}, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      if (row.strength != cfg_strength || row.mode != cfg_mode ||
          row.red_first != cfg_red_first || row.colour != cfg_colour[0] ||
          row.colour != cfg_colour[1] || row.colour != cfg_colour[2] ||
          row.colour != cfg_colour[3])
        commit_config(row.strength, row.mode, row.red_first, row.colour, row.colour,
                      row.colour, row.colour);
      offer_pixel(row.px, row.known, row.want);
      pace_sender();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = 9'd0;
        1: s = STRENGTH_FULL;
        2: s = 9'd511;
        3: s = 9'd1;
        default: s = ($urandom_range(0, 1) == 0) ? STRENGTH_W'($urandom_range(0, 256))
                                                 : STRENGTH_W'($urandom_range(0, 511));
      endcase
      m = (ph < 4) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 3));
      for (int k = 0; k < MASKS; k++) begin
        if (ph == 0)      c[k] = 24'h000000;
        else if (ph == 1) c[k] = 24'hFFFFFF;
        else              c[k] = COLOUR_W'($urandom_range(0, 24'hFFFFFF));
      end
      commit_config(s, m, ph[0] ^ 1'($urandom_range(0, 1)), c[0], c[1], c[2], c[3]);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the receiver off and keep offering until the input stalls
        if (ph == 3 && n == 0) hold_req = 1'b1;
        // pause the sender until every result is back
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_results();
        offer_pixel(random_pixel(), 1'b0, '0);
        if (!(ph == 3 && n < 30)) pace_sender();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && blend_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pmob_pkg.sv
rtl/core/pmob_if.sv
rtl/core/pmob_front.sv
rtl/core/pmob_queue.sv
rtl/core/pmob_back.sv
rtl/core/priority_mask_overlay_blend.sv
rtl/core/pmob_checker.sv
bench/priority_mask_overlay_blend_test.sv
